>>> sv/pts_pkg.sv
// Shared types, codes and helpers for the packed trit store.
package pts_pkg;

  localparam int unsigned ACT_W = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 2;
  localparam int unsigned RES_W = 11;

  localparam int unsigned MAX_WORDS_DEF      = 64;
  localparam int unsigned TRITS_PER_WORD_DEF = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_TRIM   = 2'd2,
    ACT_SHRINK = 2'd3
  } act_e;

  localparam logic [VAL_W-1:0] VAL_UNKNOWN = 2'd0;
  localparam logic [VAL_W-1:0] VAL_FALSE   = 2'd1;
  localparam logic [VAL_W-1:0] VAL_TRUE    = 2'd2;
  localparam logic [VAL_W-1:0] VAL_NONE    = 2'd3;

  localparam logic [1:0] CODE_UNKNOWN = 2'b00;
  localparam logic [1:0] CODE_FALSE   = 2'b01;
  localparam logic [1:0] CODE_TRUE    = 2'b11;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_WR_RD,
    ST_WR_WB,
    ST_TRIM_RD,
    ST_TRIM_WB,
    ST_TRIM_ZERO,
    ST_SHRINK,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] trit_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_trit;
    logic [RES_W-1:0] capacity_trits;
    logic [RES_W-1:0] length_trits;
    logic [RES_W-1:0] count_selected;
    logic             range_error;
  } res_t;

  function automatic logic [VAL_W-1:0] decode_code(logic [1:0] code);
    logic [VAL_W-1:0] val;
    if (code[1]) begin
      val = VAL_TRUE;
    end else if (code[0]) begin
      val = VAL_FALSE;
    end else begin
      val = VAL_UNKNOWN;
    end
    return val;
  endfunction

endpackage

>>> sv/packed_trit_store.sv
// Top level of the packed trit store: word memory, access sequencer and summary scan.
//
// Trits are kept two bits each, TRITS_PER_WORD to a word, in one memory of MAX_WORDS words
// with a registered read. After reset the block sweeps the memory to zero, one word a cycle,
// and holds busy high while it does so. An item is taken when start is high and busy is
// low. It first splits the index into word (DIV) and position (MOD), then its access:
// a write reads the index word and writes it back, a trim does the same and then clears
// each word above the index word, a shrink reads words from the top down and drops each
// zero word until a nonzero word or an empty store stops it. A scan then reads every
// allocated word, one per cycle, to find length and count. The result shows on res_o
// with done_o for one cycle as busy falls; it cannot be held off. The block takes no new
// item until the result of the last one is out.
module packed_trit_store #(
  parameter int unsigned MAX_WORDS      = pts_pkg::MAX_WORDS_DEF,
  parameter int unsigned TRITS_PER_WORD = pts_pkg::TRITS_PER_WORD_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pts_pkg::req_t req_i,
  output logic          done_o,
  output pts_pkg::res_t res_o
);

  localparam int unsigned WORD_W  = 2 * TRITS_PER_WORD;
  localparam int unsigned AW      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned UW      = $clog2(MAX_WORDS + 1);
  localparam int unsigned OFF_W   = (TRITS_PER_WORD > 1) ? $clog2(TRITS_PER_WORD) : 1;
  localparam int unsigned CW      = $clog2(TRITS_PER_WORD + 1);
  localparam int unsigned DIV_SH  = pts_pkg::IDX_W + OFF_W + 1;
  localparam int unsigned RECIP   = ((1 << DIV_SH) + TRITS_PER_WORD - 1) / TRITS_PER_WORD;
  localparam int unsigned RECIP_W = DIV_SH + 1;
  localparam int unsigned PROD_W  = pts_pkg::IDX_W + RECIP_W;

  pts_pkg::state_e state_q, state_d;

  pts_pkg::req_t                req_q, req_d;
  logic [pts_pkg::IDX_W-1:0]    q_q, q_d;
  logic [OFF_W-1:0]             off_q, off_d;
  logic                         q_big_q, q_big_d;
  logic [UW-1:0]                used_q, used_d;
  logic [AW-1:0]                clr_q, clr_d;
  logic [UW-1:0]                zaddr_q, zaddr_d;
  logic [UW-1:0]                scan_q, scan_d;
  logic                         pend_q, pend_d;
  logic [AW-1:0]                daddr_q, daddr_d;
  logic [pts_pkg::RES_W-1:0]    base_q, base_d;
  logic [pts_pkg::RES_W-1:0]    len_q, len_d;
  logic [pts_pkg::RES_W-1:0]    known_q, known_d;
  logic [pts_pkg::RES_W-1:0]    match_q, match_d;
  logic [pts_pkg::VAL_W-1:0]    rtrit_q, rtrit_d;
  logic                         err_q, err_d;
  logic                         done_q, done_d;
  pts_pkg::res_t                res_q, res_d;

  logic [WORD_W-1:0] mem_q [MAX_WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [PROD_W-1:0]         div_prod;
  logic [pts_pkg::IDX_W-1:0] q_c;
  logic [pts_pkg::IDX_W-1:0] qmul_c;
  logic                      q_big_c;
  logic                      q_in_used;
  logic                      trim_more;
  logic                      zero_last;
  logic                      scan_end;
  logic [pts_pkg::VAL_W-1:0] tv;
  logic [1:0]                wr_code;

  logic [CW-1:0]     w_known;
  logic [CW-1:0]     w_sel;
  logic [OFF_W-1:0]  w_last;
  logic              w_any;
  logic [1:0]        w_pair_at;
  logic [WORD_W-1:0] w_write;
  logic [WORD_W-1:0] w_trim;

  assign tv        = req_q.trit_value;
  assign div_prod  = PROD_W'(req_q.index) * PROD_W'(RECIP);
  assign q_c       = div_prod[DIV_SH +: pts_pkg::IDX_W];
  assign qmul_c    = pts_pkg::IDX_W'(32'(q_q) * 32'(TRITS_PER_WORD));
  assign q_big_c   = 32'(q_q) >= 32'(MAX_WORDS);
  assign q_in_used = 32'(q_q) < 32'(used_q);
  assign trim_more = (32'(q_q) + 32'd1) < 32'(used_q);
  assign zero_last = (32'(zaddr_q) + 32'd1) >= 32'(used_q);
  assign scan_end  = !pend_q && (scan_q == used_q);

  always_comb begin
    if (tv == pts_pkg::VAL_TRUE) begin
      wr_code = pts_pkg::CODE_TRUE;
    end else if (tv == pts_pkg::VAL_FALSE) begin
      wr_code = pts_pkg::CODE_FALSE;
    end else begin
      wr_code = pts_pkg::CODE_UNKNOWN;
    end
  end

  always_comb begin
    logic [1:0] pair;
    w_known   = '0;
    w_sel     = '0;
    w_last    = '0;
    w_any     = 1'b0;
    w_pair_at = pts_pkg::CODE_UNKNOWN;
    w_write   = rdata_q;
    w_trim    = rdata_q;
    for (int unsigned p = 0; p < TRITS_PER_WORD; p++) begin
      pair = rdata_q[2 * (TRITS_PER_WORD - 1 - p) +: 2];
      if (pair != pts_pkg::CODE_UNKNOWN) begin
        w_known = w_known + CW'(1);
        w_last  = OFF_W'(p);
        w_any   = 1'b1;
      end
      if ((tv == pts_pkg::VAL_FALSE && pair == pts_pkg::CODE_FALSE) ||
          (tv == pts_pkg::VAL_TRUE && pair[1])) begin
        w_sel = w_sel + CW'(1);
      end
      if (OFF_W'(p) == off_q) begin
        w_pair_at = pair;
        w_write[2 * (TRITS_PER_WORD - 1 - p) +: 2] = wr_code;
      end
      if (OFF_W'(p) > off_q) begin
        w_trim[2 * (TRITS_PER_WORD - 1 - p) +: 2] = pts_pkg::CODE_UNKNOWN;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::ST_CLEAR: begin
        if (clr_q == AW'(MAX_WORDS - 1)) begin
          state_d = pts_pkg::ST_IDLE;
        end
      end
      pts_pkg::ST_IDLE: begin
        if (start) begin
          state_d = pts_pkg::ST_DIV;
        end
      end
      pts_pkg::ST_DIV: state_d = pts_pkg::ST_MOD;
      pts_pkg::ST_MOD: begin
        unique case (pts_pkg::act_e'(req_q.action))
          pts_pkg::ACT_READ:   state_d = pts_pkg::ST_SCAN;
          pts_pkg::ACT_WRITE: begin
            if (tv == pts_pkg::VAL_UNKNOWN) begin
              state_d = q_in_used ? pts_pkg::ST_WR_RD : pts_pkg::ST_SCAN;
            end else if (tv == pts_pkg::VAL_NONE || q_big_c) begin
              state_d = pts_pkg::ST_SCAN;
            end else begin
              state_d = pts_pkg::ST_WR_RD;
            end
          end
          pts_pkg::ACT_TRIM:   state_d = q_in_used ? pts_pkg::ST_TRIM_RD : pts_pkg::ST_SCAN;
          pts_pkg::ACT_SHRINK: state_d = pts_pkg::ST_SHRINK;
          default:             state_d = pts_pkg::ST_SCAN;
        endcase
      end
      pts_pkg::ST_WR_RD:   state_d = pts_pkg::ST_WR_WB;
      pts_pkg::ST_WR_WB:   state_d = pts_pkg::ST_SCAN;
      pts_pkg::ST_TRIM_RD: state_d = pts_pkg::ST_TRIM_WB;
      pts_pkg::ST_TRIM_WB: state_d = trim_more ? pts_pkg::ST_TRIM_ZERO : pts_pkg::ST_SCAN;
      pts_pkg::ST_TRIM_ZERO: begin
        if (zero_last) begin
          state_d = pts_pkg::ST_SCAN;
        end
      end
      pts_pkg::ST_SHRINK: begin
        if (pend_q) begin
          if (rdata_q != '0 || used_q <= UW'(1)) begin
            state_d = pts_pkg::ST_SCAN;
          end
        end else if (used_q == '0) begin
          state_d = pts_pkg::ST_SCAN;
        end
      end
      pts_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = pts_pkg::ST_IDLE;
        end
      end
      default: state_d = pts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_d     = req_q;
    q_d       = q_q;
    off_d     = off_q;
    q_big_d   = q_big_q;
    used_d    = used_q;
    clr_d     = clr_q;
    zaddr_d   = zaddr_q;
    scan_d    = scan_q;
    pend_d    = pend_q;
    daddr_d   = daddr_q;
    base_d    = base_q;
    len_d     = len_q;
    known_d   = known_q;
    match_d   = match_q;
    rtrit_d   = rtrit_q;
    err_d     = err_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = AW'(q_q);
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = AW'(q_q);
    unique case (state_q)
      pts_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
      end
      pts_pkg::ST_IDLE: begin
        if (start) begin
          req_d = req_i;
        end
      end
      pts_pkg::ST_DIV: q_d = q_c;
      pts_pkg::ST_MOD: begin
        off_d   = OFF_W'(req_q.index - qmul_c);
        q_big_d = q_big_c;
        scan_d  = '0;
        pend_d  = 1'b0;
        base_d  = '0;
        len_d   = '0;
        known_d = '0;
        match_d = '0;
        rtrit_d = pts_pkg::VAL_UNKNOWN;
        err_d   = 1'b0;
        if (pts_pkg::act_e'(req_q.action) == pts_pkg::ACT_WRITE &&
            (tv == pts_pkg::VAL_FALSE || tv == pts_pkg::VAL_TRUE)) begin
          if (q_big_c) begin
            err_d = 1'b1;
          end else if (!q_in_used) begin
            used_d = UW'(q_q) + UW'(1);
          end
        end
      end
      pts_pkg::ST_WR_RD: mem_re = 1'b1;
      pts_pkg::ST_WR_WB: begin
        mem_we    = 1'b1;
        mem_wdata = w_write;
      end
      pts_pkg::ST_TRIM_RD: mem_re = 1'b1;
      pts_pkg::ST_TRIM_WB: begin
        mem_we    = 1'b1;
        mem_wdata = w_trim;
        zaddr_d   = UW'(q_q) + UW'(1);
      end
      pts_pkg::ST_TRIM_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(zaddr_q);
        zaddr_d   = zaddr_q + UW'(1);
      end
      pts_pkg::ST_SHRINK: begin
        pend_d = 1'b0;
        if (pend_q) begin
          if (rdata_q == '0) begin
            used_d = used_q - UW'(1);
            if (used_q > UW'(1)) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(used_q - UW'(2));
              pend_d    = 1'b1;
            end
          end
        end else if (used_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(used_q - UW'(1));
          pend_d    = 1'b1;
        end
      end
      pts_pkg::ST_SCAN: begin
        pend_d = 1'b0;
        if (scan_q != used_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(scan_q);
          daddr_d   = AW'(scan_q);
          scan_d    = scan_q + UW'(1);
          pend_d    = 1'b1;
        end
        if (pend_q) begin
          base_d  = base_q + pts_pkg::RES_W'(TRITS_PER_WORD);
          known_d = known_q + pts_pkg::RES_W'(w_known);
          match_d = match_q + pts_pkg::RES_W'(w_sel);
          if (w_any) begin
            len_d = base_q + pts_pkg::RES_W'(w_last) + pts_pkg::RES_W'(1);
          end
          if (!q_big_q && daddr_q == AW'(q_q)) begin
            rtrit_d = pts_pkg::decode_code(w_pair_at);
          end
        end
        if (scan_end) begin
          done_d               = 1'b1;
          res_d.read_trit      = rtrit_q;
          res_d.capacity_trits = pts_pkg::RES_W'(32'(used_q) * 32'(TRITS_PER_WORD));
          res_d.length_trits   = len_q;
          res_d.range_error    = err_q;
          if (tv == pts_pkg::VAL_UNKNOWN) begin
            res_d.count_selected = len_q - known_q;
          end else if (tv == pts_pkg::VAL_NONE) begin
            res_d.count_selected = '0;
          end else begin
            res_d.count_selected = match_q;
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::ST_CLEAR;
      used_q  <= '0;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    q_q     <= q_d;
    off_q   <= off_d;
    q_big_q <= q_big_d;
    zaddr_q <= zaddr_d;
    scan_q  <= scan_d;
    daddr_q <= daddr_d;
    base_q  <= base_d;
    len_q   <= len_d;
    known_q <= known_d;
    match_q <= match_d;
    rtrit_q <= rtrit_d;
    err_q   <= err_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign busy   = (state_q != pts_pkg::ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef NO_ASSERTIONS
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted transfer did not make the block busy");

  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= 32'(MAX_WORDS))
    else $error("allocation beyond memory depth");

  a_no_idle_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::ST_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_err_holds_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.range_error) |-> $stable(used_q))
    else $error("range error changed the allocation");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the packed trit store: queued command driver, result monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORDS = pts_pkg::MAX_WORDS_DEF;
  localparam int unsigned TPW   = pts_pkg::TRITS_PER_WORD_DEF;

  typedef struct {
    pts_pkg::req_t req;
    bit            drain;
    int unsigned   idle_pct;
  } cmd_t;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  pts_pkg::req_t req_i  = '0;
  logic          busy;
  logic          done_o;
  pts_pkg::res_t res_o;

  cmd_t          cmd_queue[$];
  pts_pkg::res_t pending_results[$];
  int unsigned   accepted_cnt = 0;
  int unsigned   result_cnt   = 0;
  int unsigned   error_cnt    = 0;

  logic [2*TPW-1:0] trit_mem [WORDS];
  int unsigned      alloc_words;

  packed_trit_store u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int unsigned trit_shift(int unsigned pos);
    return 2 * (TPW - 1 - (pos % TPW));
  endfunction

  function automatic logic [1:0] stored_code(int unsigned pos);
    int unsigned w;
    w = pos / TPW;
    if (w >= alloc_words || w >= WORDS) begin
      return pts_pkg::CODE_UNKNOWN;
    end
    return trit_mem[w][trit_shift(pos) +: 2];
  endfunction

  function automatic logic [pts_pkg::VAL_W-1:0] trit_of_code(logic [1:0] code);
    if (code[1]) begin
      return pts_pkg::VAL_TRUE;
    end
    return code[0] ? pts_pkg::VAL_FALSE : pts_pkg::VAL_UNKNOWN;
  endfunction

  function automatic void store_code(int unsigned pos, logic [1:0] code);
    int unsigned w;
    w = pos / TPW;
    if (w < WORDS) begin
      trit_mem[w][trit_shift(pos) +: 2] = code;
    end
  endfunction

  // Apply one access to the shadow store and return the result it yields.
  function automatic pts_pkg::res_t apply_access(pts_pkg::req_t r);
    pts_pkg::res_t res;
    int unsigned   cap;
    int unsigned   idx;
    int unsigned   w;
    int unsigned   len;
    int unsigned   cnt;
    logic          err;
    idx = r.index;
    cap = alloc_words * TPW;
    err = 1'b0;
    if (r.action == pts_pkg::ACT_WRITE) begin
      if (r.trit_value == pts_pkg::VAL_UNKNOWN) begin
        if (idx < cap) store_code(idx, pts_pkg::CODE_UNKNOWN);
      end else if (r.trit_value == pts_pkg::VAL_FALSE ||
                   r.trit_value == pts_pkg::VAL_TRUE) begin
        w = idx / TPW;
        if (w >= WORDS) begin
          err = 1'b1;
        end else begin
          if (idx >= cap) alloc_words = w + 1;
          store_code(idx, (r.trit_value == pts_pkg::VAL_TRUE) ? pts_pkg::CODE_TRUE :
                                                                pts_pkg::CODE_FALSE);
        end
      end
    end else if (r.action == pts_pkg::ACT_TRIM) begin
      if (idx < cap) begin
        for (int unsigned i = idx + 1; i < cap; i++) store_code(i, pts_pkg::CODE_UNKNOWN);
      end
    end else if (r.action == pts_pkg::ACT_SHRINK) begin
      while (alloc_words > 0 && trit_mem[alloc_words-1] == '0) alloc_words--;
    end
    len = alloc_words * TPW;
    while (len > 0 && stored_code(len - 1) == pts_pkg::CODE_UNKNOWN) len--;
    cnt = 0;
    if (r.trit_value != pts_pkg::VAL_NONE) begin
      for (int unsigned i = 0; i < len; i++) begin
        if (trit_of_code(stored_code(i)) == r.trit_value) cnt++;
      end
    end
    res.read_trit      = trit_of_code(stored_code(idx));
    res.capacity_trits = pts_pkg::RES_W'(alloc_words * TPW);
    res.length_trits   = pts_pkg::RES_W'(len);
    res.count_selected = pts_pkg::RES_W'(cnt);
    res.range_error    = err;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_cnt++;
    end
  endfunction

  function automatic void push_cmd(pts_pkg::act_e act, int unsigned idx,
                                   logic [pts_pkg::VAL_W-1:0] tv,
                                   bit drain, int unsigned idle_pct);
    cmd_t c;
    c.req.action     = act;
    c.req.index      = pts_pkg::IDX_W'(idx);
    c.req.trit_value = tv;
    c.drain          = drain;
    c.idle_pct       = idle_pct;
    cmd_queue.push_back(c);
  endfunction

  function automatic void push_random(bit drain, int unsigned idle_pct);
    int unsigned               sel;
    int unsigned               idx;
    int unsigned               v;
    pts_pkg::act_e             act;
    logic [pts_pkg::VAL_W-1:0] tv;
    sel = $urandom_range(0, 99);
    if (sel < 45)      act = pts_pkg::ACT_WRITE;
    else if (sel < 70) act = pts_pkg::ACT_READ;
    else if (sel < 85) act = pts_pkg::ACT_TRIM;
    else               act = pts_pkg::ACT_SHRINK;
    sel = $urandom_range(0, 99);
    if (sel < 55)      idx = $urandom_range(0, 95);
    else if (sel < 75) idx = $urandom_range(0, 1023);
    else               idx = $urandom_range(0, 63) * TPW + ($urandom_range(0, 1) ? TPW - 1 : 0);
    v = $urandom_range(0, 15);
    if (v == 0)       tv = pts_pkg::VAL_NONE;
    else if (v < 4)   tv = pts_pkg::VAL_UNKNOWN;
    else if (v < 10)  tv = pts_pkg::VAL_FALSE;
    else              tv = pts_pkg::VAL_TRUE;
    push_cmd(act, idx, tv, drain, idle_pct);
  endfunction

  always @(posedge clk_i) begin : drive_proc
    bit took;
    bit go;
    took = start && !busy;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        pending_results.push_back(apply_access(req_i));
        accepted_cnt <= accepted_cnt + 1;
        void'(cmd_queue.pop_front());
      end
      if (!start || took) begin
        go = 1'b0;
        if (cmd_queue.size() != 0) begin
          if (cmd_queue[0].drain) begin
            go = !took && (accepted_cnt == result_cnt);
          end else begin
            go = ($urandom_range(0, 99) >= cmd_queue[0].idle_pct);
          end
        end
        start <= go;
        if (go) req_i <= cmd_queue[0].req;
      end
    end
  end

  always @(posedge clk_i) begin : watch_proc
    pts_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (result_cnt >= accepted_cnt || pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %p", $time, res_o);
        error_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_trit", want.read_trit, res_o.read_trit);
        check_field("capacity_trits", want.capacity_trits, res_o.capacity_trits);
        check_field("length_trits", want.length_trits, res_o.length_trits);
        check_field("count_selected", want.count_selected, res_o.count_selected);
        check_field("range_error", want.range_error, res_o.range_error);
        result_cnt <= result_cnt + 1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("packed_trit_store verification failed");
    $finish;
  end

  initial begin : stim_proc
    int unsigned phase_idle [4];
    phase_idle = '{0, 81, 0, 25};
    for (int unsigned i = 0; i < WORDS; i++) trit_mem[i] = '0;
    alloc_words = 0;

    push_cmd(pts_pkg::ACT_READ,   0,    pts_pkg::VAL_FALSE,   0, 0);
    push_cmd(pts_pkg::ACT_READ,   1023, pts_pkg::VAL_UNKNOWN, 0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  500,  pts_pkg::VAL_UNKNOWN, 0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  0,    pts_pkg::VAL_TRUE,    0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  15,   pts_pkg::VAL_FALSE,   0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  16,   pts_pkg::VAL_TRUE,    0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  5,    pts_pkg::VAL_NONE,    0, 0);
    push_cmd(pts_pkg::ACT_READ,   5,    pts_pkg::VAL_NONE,    0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  1023, pts_pkg::VAL_TRUE,    0, 0);
    push_cmd(pts_pkg::ACT_READ,   1023, pts_pkg::VAL_TRUE,    0, 0);
    push_cmd(pts_pkg::ACT_READ,   600,  pts_pkg::VAL_UNKNOWN, 0, 0);
    push_cmd(pts_pkg::ACT_TRIM,   1023, pts_pkg::VAL_FALSE,   0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  1023, pts_pkg::VAL_UNKNOWN, 0, 0);
    push_cmd(pts_pkg::ACT_SHRINK, 0,    pts_pkg::VAL_TRUE,    0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  1000, pts_pkg::VAL_FALSE,   0, 0);
    push_cmd(pts_pkg::ACT_TRIM,   1010, pts_pkg::VAL_FALSE,   0, 0);
    push_cmd(pts_pkg::ACT_TRIM,   999,  pts_pkg::VAL_TRUE,    0, 0);
    push_cmd(pts_pkg::ACT_TRIM,   7,    pts_pkg::VAL_FALSE,   0, 0);
    push_cmd(pts_pkg::ACT_SHRINK, 1023, pts_pkg::VAL_FALSE,   0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  0,    pts_pkg::VAL_UNKNOWN, 0, 0);
    push_cmd(pts_pkg::ACT_SHRINK, 0,    pts_pkg::VAL_UNKNOWN, 0, 0);
    push_cmd(pts_pkg::ACT_READ,   0,    pts_pkg::VAL_UNKNOWN, 0, 0);
    push_cmd(pts_pkg::ACT_WRITE,  1008, pts_pkg::VAL_FALSE,   0, 0);
    push_cmd(pts_pkg::ACT_READ,   682,  pts_pkg::VAL_TRUE,    0, 0);
    push_cmd(pts_pkg::ACT_READ,   341,  pts_pkg::VAL_FALSE,   1, 0);

    for (int unsigned p = 0; p < 4; p++) begin
      for (int unsigned n = 0; n < 200; n++) begin
        push_random((n == 0) || ($urandom_range(0, 99) == 0), phase_idle[p]);
      end
    end

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || start) @(posedge clk_i);
    while (result_cnt != accepted_cnt) @(posedge clk_i);
    repeat (2 * WORDS + 16) @(posedge clk_i);

    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("packed_trit_store verification clean");
    end else begin
      $display("packed_trit_store verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/pts_pkg.sv
sv/packed_trit_store.sv
tb/sv/tb.sv
